[hw/rtl/etti_pkg.sv]
// ----------------------------------------------------------------------------
// Ewald table trilinear interpolator: shared definitions
// Grid geometry, bank layout, fixed-point widths and table word type.
// ----------------------------------------------------------------------------
package etti_pkg;

    // Grid geometry over one octant.
    localparam int GRID_CELLS  = 16;
    localparam int GRID_POINTS = GRID_CELLS + 1;
    localparam int PLANE       = GRID_POINTS * GRID_POINTS;
    localparam int TABLE_DEPTH = PLANE * GRID_POINTS;

    // Field widths.
    localparam int IDX_W  = 13;
    localparam int DATA_W = 32;
    localparam int FRAC_W = 17;
    localparam int CELL_W = $clog2(GRID_POINTS);

    // Eight banks split by the parity of each grid coordinate.
    localparam int NUM_BANKS  = 8;
    localparam int HALF       = GRID_CELLS / 2 + 1;
    localparam int BANK_DEPTH = HALF * HALF * HALF;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // Reciprocals for splitting a linear grid index.
    localparam int RECIP_SH   = 24;
    localparam int RECIP_PLANE = (1 << RECIP_SH) / PLANE;
    localparam int RECIP_ROW   = (1 << RECIP_SH) / GRID_POINTS;
    localparam int QPROD_W     = IDX_W + RECIP_SH;

    // Tables held in one bank word.
    localparam int NUM_TABLES = 4;
    localparam int TBL_FX     = 0;
    localparam int TBL_FY     = 1;
    localparam int TBL_FZ     = 2;
    localparam int TBL_POT    = 3;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

    typedef logic [NUM_TABLES-1:0][DATA_W-1:0] table_word_t;

endpackage

[hw/rtl/ewald_table_trilinear_interp.sv]
// ----------------------------------------------------------------------------
// Ewald table trilinear interpolator
// Four grid tables (force x, y, z, potential) in eight parity banks; loads
// write one grid point, evaluates interpolate between eight cell corners.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  cfg     | cfg_valid / cfg_ready / cfg_data | grid_scale write request
//  in      | in_valid / in_ready + fields     | load or evaluate request
//  out     | out_valid / out_ready + fields   | one result per evaluate
//
// Ten register stages; one request enters per cycle while the output is not
// stalled. The eight banks give each cell corner its own read port, so
// lookups keep full rate. Reset clears the stage valid bits and sets
// grid_scale to 65536; table contents are undefined until loaded. A full
// stage holds while the stage ahead does not move on.
// ----------------------------------------------------------------------------
module ewald_table_trilinear_interp
    import etti_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [31:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [DATA_W-1:0] entry_force_x,
    input  logic signed [DATA_W-1:0] entry_force_y,
    input  logic signed [DATA_W-1:0] entry_force_z,
    input  logic signed [DATA_W-1:0] entry_potential,
    input  logic signed [DATA_W-1:0] offset_x,
    input  logic signed [DATA_W-1:0] offset_y,
    input  logic signed [DATA_W-1:0] offset_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] force_x,
    output logic signed [DATA_W-1:0] force_y,
    output logic signed [DATA_W-1:0] force_z,
    output logic signed [DATA_W-1:0] potential
);

    localparam int NST       = 10;
    localparam int STAGE_MEM = 6;

    // Pipeline control.
    logic [NST:1] v_reg, v_next, take;
    logic [31:0]  grid_scale_reg;

    // Stage 1.
    logic              kind1_reg;
    logic [IDX_W-1:0]  idx1_reg, qi1_next, qi1_reg;
    logic [QPROD_W-1:0] qprod_i;
    table_word_t       ent1_next, ent1_reg;
    logic [2:0][DATA_W-1:0] off1;
    logic [2:0][31:0]  mag1_next, mag1_reg;
    logic [2:0]        neg1_reg;

    // Stage 2.
    logic              kind2_reg, ok2_reg;
    table_word_t       ent2_reg;
    logic [2:0]        neg2_reg;
    logic [2:0][63:0]  p2_next, p2_reg;
    logic [IDX_W-1:0]  rem_raw_i, i2_next, i2_reg, rem2_next, rem2_reg;

    // Stage 3.
    logic              kind3_reg, ok3_reg;
    table_word_t       ent3_reg;
    logic [2:0]        neg3_reg;
    logic [2:0][CELL_W-1:0] cell3_next, cell3_reg;
    logic [2:0][FRAC_W-1:0] frac3_next, frac3_reg;
    logic [IDX_W-1:0]  i3_reg, rem3_reg, qj3_next, qj3_reg;
    logic [QPROD_W-1:0] qprod_j;

    // Stage 4.
    logic              kind4_reg, ok4_reg;
    table_word_t       ent4_reg;
    logic [2:0]        neg4_reg;
    logic [2:0][FRAC_W-1:0] frac4_reg;
    logic [IDX_W-1:0]  rem_raw_j, j4, k4;
    logic [2:0][CELL_W-1:0] coord4_next, coord4_reg;

    // Stage 5.
    logic              kind5_reg;
    table_word_t       ent5_reg;
    logic [2:0]        neg5_reg, par5_reg;
    logic [2:0][FRAC_W-1:0] frac5_reg;
    logic [NUM_BANKS-1:0][BANK_AW-1:0] addr5_next, addr5_reg;
    logic [NUM_BANKS-1:0] we5_next, we5_reg;

    // Stage 6 (bank read data lives in the banks).
    table_word_t       rd6 [NUM_BANKS];
    table_word_t       corner [NUM_BANKS];
    logic [2:0]        neg6_reg, par6_reg;
    logic [2:0][FRAC_W-1:0] frac6_reg;

    // Stages 7 to 9 (lerp results live in the lanes).
    logic [NUM_TABLES-1:0][3:0][DATA_W-1:0] z7;
    logic [NUM_TABLES-1:0][1:0][DATA_W-1:0] y8;
    logic [NUM_TABLES-1:0][DATA_W-1:0]      x9;
    logic [2:0]        neg7_reg, neg8_reg, neg9_reg;
    logic [FRAC_W-1:0] dy7_reg, dx7_reg, dx8_reg;

    // Stage 10.
    logic [NUM_TABLES-1:0][DATA_W-1:0] res10_next, res10_reg;

    // Each stage loads when it is empty or the stage ahead moves on.
    always_comb
    begin
        take[NST] = !v_reg[NST] || out_ready;
        for (int s = NST - 1; s >= 1; s--)
        begin
            take[s] = !v_reg[s] || take[s+1];
        end
    end

    // Valid bits advance with the data; loads end at the banks.
    always_comb
    begin
        v_next = v_reg;
        if (take[1])
        begin
            v_next[1] = in_valid;
        end
        for (int s = 2; s <= NST; s++)
        begin
            if (take[s])
            begin
                v_next[s] = v_reg[s-1];
            end
        end
        if (take[STAGE_MEM])
        begin
            v_next[STAGE_MEM] = v_reg[STAGE_MEM-1] && kind5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            grid_scale_reg <= 32'd65536;
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_valid)
            begin
                grid_scale_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = take[1];
    assign out_valid = v_reg[NST];

    // Stage 1: magnitudes, sign flags and the first index quotient estimate.
    always_comb
    begin
        off1[0] = offset_x;
        off1[1] = offset_y;
        off1[2] = offset_z;
        for (int a = 0; a < 3; a++)
        begin
            mag1_next[a] = off1[a][DATA_W-1] ? (~off1[a] + 32'd1) : off1[a];
        end
        ent1_next[TBL_FX]  = entry_force_x;
        ent1_next[TBL_FY]  = entry_force_y;
        ent1_next[TBL_FZ]  = entry_force_z;
        ent1_next[TBL_POT] = entry_potential;
        qprod_i  = QPROD_W'(entry_index) * QPROD_W'(RECIP_PLANE);
        qi1_next = qprod_i[QPROD_W-1:RECIP_SH];
    end

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            kind1_reg <= kind;
            idx1_reg  <= entry_index;
            qi1_reg   <= qi1_next;
            ent1_reg  <= ent1_next;
            mag1_reg  <= mag1_next;
            neg1_reg  <= {off1[2][DATA_W-1], off1[1][DATA_W-1], off1[0][DATA_W-1]};
        end
    end

    // Stage 2: scale to grid units; finish the plane index.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            p2_next[a] = 64'(mag1_reg[a]) * 64'(grid_scale_reg);
        end
        rem_raw_i = idx1_reg - IDX_W'(int'(qi1_reg) * PLANE);
        if (rem_raw_i >= IDX_W'(PLANE))
        begin
            i2_next   = qi1_reg + IDX_W'(1);
            rem2_next = rem_raw_i - IDX_W'(PLANE);
        end
        else
        begin
            i2_next   = qi1_reg;
            rem2_next = rem_raw_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[2])
        begin
            kind2_reg <= kind1_reg;
            ok2_reg   <= (int'(idx1_reg) < TABLE_DEPTH);
            ent2_reg  <= ent1_reg;
            neg2_reg  <= neg1_reg;
            p2_reg    <= p2_next;
            i2_reg    <= i2_next;
            rem2_reg  <= rem2_next;
        end
    end

    // Stage 3: cell index and fraction, held at the last cell past the edge.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (p2_reg[a][63:32] >= 32'(GRID_CELLS))
            begin
                cell3_next[a] = CELL_W'(GRID_CELLS - 1);
                frac3_next[a] = FRAC_ONE;
            end
            else
            begin
                cell3_next[a] = p2_reg[a][32+CELL_W-1:32];
                frac3_next[a] = {1'b0, p2_reg[a][31:16]};
            end
        end
        qprod_j  = QPROD_W'(rem2_reg) * QPROD_W'(RECIP_ROW);
        qj3_next = qprod_j[QPROD_W-1:RECIP_SH];
    end

    always_ff @(posedge clk)
    begin
        if (take[3])
        begin
            kind3_reg <= kind2_reg;
            ok3_reg   <= ok2_reg;
            ent3_reg  <= ent2_reg;
            neg3_reg  <= neg2_reg;
            cell3_reg <= cell3_next;
            frac3_reg <= frac3_next;
            i3_reg    <= i2_reg;
            rem3_reg  <= rem2_reg;
            qj3_reg   <= qj3_next;
        end
    end

    // Stage 4: finish the row index; pick the coordinates for this request.
    always_comb
    begin
        rem_raw_j = rem3_reg - IDX_W'(int'(qj3_reg) * GRID_POINTS);
        if (rem_raw_j >= IDX_W'(GRID_POINTS))
        begin
            j4 = qj3_reg + IDX_W'(1);
            k4 = rem_raw_j - IDX_W'(GRID_POINTS);
        end
        else
        begin
            j4 = qj3_reg;
            k4 = rem_raw_j;
        end
        if (kind3_reg)
        begin
            coord4_next = cell3_reg;
        end
        else
        begin
            coord4_next[0] = i3_reg[CELL_W-1:0];
            coord4_next[1] = j4[CELL_W-1:0];
            coord4_next[2] = k4[CELL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[4])
        begin
            kind4_reg  <= kind3_reg;
            ok4_reg    <= ok3_reg;
            ent4_reg   <= ent3_reg;
            neg4_reg   <= neg3_reg;
            frac4_reg  <= frac3_reg;
            coord4_reg <= coord4_next;
        end
    end

    // Stage 5: bank addresses. Each bank holds the corner of its own parity;
    // a load writes only the bank that matches its grid point.
    always_comb
    begin
        logic [2:0]                  bsel;
        logic [2:0][CELL_W-1:0]      pos;
        logic [2:0][CELL_W-2:0]      half;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bsel = 3'(b);
            for (int a = 0; a < 3; a++)
            begin
                pos[a]  = coord4_reg[a]
                        + CELL_W'(kind4_reg & (bsel[2-a] ^ coord4_reg[a][0]));
                half[a] = pos[a][CELL_W-1:1];
            end
            addr5_next[b] = BANK_AW'(int'(half[0]) * HALF * HALF
                                   + int'(half[1]) * HALF + int'(half[2]));
            we5_next[b]   = !kind4_reg && ok4_reg
                         && (bsel == {coord4_reg[0][0], coord4_reg[1][0],
                                      coord4_reg[2][0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[5])
        begin
            kind5_reg <= kind4_reg;
            ent5_reg  <= ent4_reg;
            neg5_reg  <= neg4_reg;
            frac5_reg <= frac4_reg;
            par5_reg  <= {coord4_reg[2][0], coord4_reg[1][0], coord4_reg[0][0]};
            addr5_reg <= addr5_next;
            we5_reg   <= we5_next;
        end
    end

    // Stage 6: bank access.
    for (genvar gb = 0; gb < NUM_BANKS; gb++)
    begin : g_bank
        etti_bank u_bank (
            .clk   (clk),
            .en    (take[STAGE_MEM]),
            .we    (v_reg[STAGE_MEM-1] && we5_reg[gb]),
            .addr  (addr5_reg[gb]),
            .wdata (ent5_reg),
            .rdata (rd6[gb])
        );
    end

    always_ff @(posedge clk)
    begin
        if (take[STAGE_MEM])
        begin
            neg6_reg  <= neg5_reg;
            par6_reg  <= par5_reg;
            frac6_reg <= frac5_reg;
        end
    end

    // Put bank words back in corner order {x, y, z}.
    always_comb
    begin
        for (int n = 0; n < NUM_BANKS; n++)
        begin
            corner[n] = rd6[3'(n) ^ {par6_reg[0], par6_reg[1], par6_reg[2]}];
        end
    end

    // Stages 7 to 9: interpolate along z, then y, then x.
    for (genvar gt = 0; gt < NUM_TABLES; gt++)
    begin : g_tbl
        for (genvar gc = 0; gc < 4; gc++)
        begin : g_z
            etti_lerp u_lerp_z (
                .clk (clk),
                .en  (take[7]),
                .a   (corner[2*gc][gt]),
                .b   (corner[2*gc+1][gt]),
                .d   (frac6_reg[2]),
                .y   (z7[gt][gc])
            );
        end
        for (genvar gc = 0; gc < 2; gc++)
        begin : g_y
            etti_lerp u_lerp_y (
                .clk (clk),
                .en  (take[8]),
                .a   (z7[gt][2*gc]),
                .b   (z7[gt][2*gc+1]),
                .d   (dy7_reg),
                .y   (y8[gt][gc])
            );
        end
        etti_lerp u_lerp_x (
            .clk (clk),
            .en  (take[9]),
            .a   (y8[gt][0]),
            .b   (y8[gt][1]),
            .d   (dx8_reg),
            .y   (x9[gt])
        );
    end

    always_ff @(posedge clk)
    begin
        if (take[7])
        begin
            neg7_reg <= neg6_reg;
            dy7_reg  <= frac6_reg[1];
            dx7_reg  <= frac6_reg[0];
        end
        if (take[8])
        begin
            neg8_reg <= neg7_reg;
            dx8_reg  <= dx7_reg;
        end
        if (take[9])
        begin
            neg9_reg <= neg8_reg;
        end
    end

    // Stage 10: forces point against the offset; zero offset counts positive.
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            if (neg9_reg[t])
            begin
                res10_next[t] = x9[t];
            end
            else if (x9[t] == {1'b1, {(DATA_W-1){1'b0}}})
            begin
                res10_next[t] = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                res10_next[t] = ~x9[t] + DATA_W'(1);
            end
        end
        res10_next[TBL_POT] = x9[TBL_POT];
    end

    always_ff @(posedge clk)
    begin
        if (take[NST])
        begin
            res10_reg <= res10_next;
        end
    end

    assign force_x   = res10_reg[TBL_FX];
    assign force_y   = res10_reg[TBL_FY];
    assign force_z   = res10_reg[TBL_FZ];
    assign potential = res10_reg[TBL_POT];

endmodule

[hw/rtl/etti_bank.sv]
// ----------------------------------------------------------------------------
// Grid bank
// One parity bank of all four tables, one access a cycle while enabled, registered read.
// ----------------------------------------------------------------------------
module etti_bank
    import etti_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [BANK_AW-1:0] addr,
    input  table_word_t        wdata,
    output table_word_t        rdata
);

    table_word_t mem [BANK_DEPTH];
    table_word_t rdata_reg;

    // A load writes the word, an evaluate reads it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/etti_lerp.sv]
// ----------------------------------------------------------------------------
// Linear interpolation lane
// Registered floor(a*(1-d) + b*d + 0.5) with d in Q1.16, one multiply.
// ----------------------------------------------------------------------------
module etti_lerp
    import etti_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic [FRAC_W-1:0] d,
    output logic [DATA_W-1:0] y
);

    logic signed [DATA_W:0]   diff;
    logic signed [FRAC_W:0]   d_s;
    logic signed [DATA_W+18:0] prod;
    logic signed [DATA_W+18:0] sum;
    logic [DATA_W-1:0]        y_next;
    logic [DATA_W-1:0]        y_reg;

    // a*(1-d) + b*d is rewritten as a + (b-a)*d.
    always_comb
    begin
        diff   = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
        d_s    = $signed({1'b0, d});
        prod   = (DATA_W+19)'(diff) * (DATA_W+19)'(d_s);
        sum    = ((DATA_W+19)'($signed(a)) <<< 16) + prod + (DATA_W+19)'(32768);
        y_next = sum[DATA_W+15:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule
